// ===== rtl/pbb_pkg.sv =====
// Shared types and constants for the primitive band binner.
package pbb_pkg;

	localparam int Y_W        = 21;
	localparam int H_W        = 14;
	localparam int N_W        = 5;
	localparam int SEL_W      = 4;
	localparam int MASK_BANDS = 16;
	localparam int CNT_W      = 32;
	localparam int KIND_W     = 2;

	localparam logic [H_W-1:0] HEIGHT_RST = 14'd1024;
	localparam logic [N_W-1:0] BANDS_RST  = 5'd1;

	typedef enum logic [1:0] {
		CMD_VERTEX = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_HEIGHT = 1'b0,
		REG_BANDS  = 1'b1
	} reg_idx_t;

	typedef enum logic {
		REPLY_ROUTE = 1'b0,
		REPLY_COUNT = 1'b1
	} reply_t;

	typedef enum logic [KIND_W-1:0] {
		DEST_NONE = 2'd0,
		DEST_ONE  = 2'd1,
		DEST_MANY = 2'd2
	} dest_kind_t;

	// Request from the band walk to the counter file.
	typedef struct packed {
		logic             inc;
		logic             clr;
		logic [SEL_W-1:0] idx;
	} cnt_req_t;

endpackage

// ===== rtl/pbb_div.sv =====
// Restoring divider: image height over band count, one quotient bit per cycle.
module pbb_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pbb_pkg::H_W-1:0]   dividend,
	input  logic [pbb_pkg::N_W-1:0]   divisor,
	output logic                      done,
	output logic [pbb_pkg::H_W-1:0]   quo,
	output logic [pbb_pkg::N_W-1:0]   rem
);

	localparam int STEP_W = $clog2(pbb_pkg::H_W);

	logic                      busy_q;
	logic                      done_q;
	logic [STEP_W-1:0]         step_q;
	logic [pbb_pkg::H_W-1:0]   quo_q;
	logic [pbb_pkg::N_W-1:0]   rem_q;
	logic [pbb_pkg::N_W-1:0]   dvs_q;
	logic [pbb_pkg::N_W:0]     trial;
	logic [pbb_pkg::N_W:0]     diff;
	logic                      ge;

	always_comb begin
		trial = {rem_q, quo_q[pbb_pkg::H_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(pbb_pkg::H_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the low bits hold it
			rem_q <= ge ? diff[pbb_pkg::N_W-1:0] : trial[pbb_pkg::N_W-1:0];
			quo_q <= {quo_q[pbb_pkg::H_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/pbb_counters.sv =====
// Per-band saturating primitive counters with a clear that resets every band together.
module pbb_counters #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pbb_pkg::cnt_req_t           req,
	input  logic [pbb_pkg::SEL_W-1:0]   rd_sel,
	output logic [pbb_pkg::CNT_W-1:0]   rd_data
);

	logic [pbb_pkg::CNT_W-1:0] cnt_q [pbb_pkg::MASK_BANDS];

	for (genvar j = 0; j < pbb_pkg::MASK_BANDS; j++) begin : g_cnt
		if (j < DEPTH) begin : g_live
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q[j] <= '0;
				end else if (req.clr) begin
					cnt_q[j] <= '0;
				end else if (req.inc && req.idx == pbb_pkg::SEL_W'(j) && cnt_q[j] != '1) begin
					cnt_q[j] <= cnt_q[j] + pbb_pkg::CNT_W'(1);
				end
			end
		end else begin : g_none
			assign cnt_q[j] = '0;
		end
	end

	assign rd_data = cnt_q[rd_sel];

endmodule

// ===== rtl/primitive_band_binner_core.sv =====
// Top level: extent tracking, band walk sequencer and result register.
//
//   channel   signals                                         dir
//   input     in_valid/in_ready, command, vertex_y,           in
//             last_vertex, band_select
//   output    out_valid/out_ready, reply_kind, dest_mask,     out
//             dest_kind, first_dest, count_value
//   config    cfg_we, cfg_index, cfg_data                     in
//
// A non-final vertex or clear is taken directly; a count read passes through a
// read state. A final vertex passes through transfer, 14 divider steps, quotient
// hand-off, one boundary compare per band in use and the result register load.
// Reset clears extent, counters and the result valid flag; no clearing pass.
// A result waiting on out_ready holds the next final vertex or read in its last
// cycle; other commands keep flowing.
module primitive_band_binner_core #(
	parameter int NUM_BANDS       = 16,
	parameter int COORD_FRAC_BITS = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         command,
	input  logic signed [pbb_pkg::Y_W-1:0]     vertex_y,
	input  logic                               last_vertex,
	input  logic [pbb_pkg::SEL_W-1:0]          band_select,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               reply_kind,
	output logic [pbb_pkg::MASK_BANDS-1:0]     dest_mask,
	output logic [pbb_pkg::KIND_W-1:0]         dest_kind,
	output logic [pbb_pkg::SEL_W-1:0]          first_dest,
	output logic [pbb_pkg::CNT_W-1:0]          count_value,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [pbb_pkg::H_W-1:0]            cfg_data
);

	localparam int MAXB  = (NUM_BANDS < pbb_pkg::MASK_BANDS) ? NUM_BANDS : pbb_pkg::MASK_BANDS;
	localparam int BND_W = pbb_pkg::H_W + COORD_FRAC_BITS + 1;
	localparam int CMP_W = (BND_W > pbb_pkg::Y_W) ? BND_W : pbb_pkg::Y_W;
	localparam int N_W   = pbb_pkg::N_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_WALK = 5'b00100,
		ST_DONE = 5'b01000,
		ST_RD   = 5'b10000
	} state_t;

	state_t                           state_q;
	logic [pbb_pkg::H_W-1:0]          height_q;
	logic [N_W-1:0]                   bands_q;
	logic signed [pbb_pkg::Y_W-1:0]   min_q;
	logic signed [pbb_pkg::Y_W-1:0]   max_q;
	logic                             inside_q;
	logic [N_W-1:0]                   n_q;
	logic [pbb_pkg::SEL_W-1:0]        sel_q;
	logic [pbb_pkg::SEL_W-1:0]        idx_q;
	logic [pbb_pkg::H_W-1:0]          hq_q;
	logic [N_W-1:0]                   hr_q;
	logic [pbb_pkg::H_W-1:0]          lo_q;
	logic [N_W-1:0]                   rem_q;
	logic [pbb_pkg::MASK_BANDS-1:0]   mask_q;
	pbb_pkg::dest_kind_t              kind_q;
	logic [pbb_pkg::SEL_W-1:0]        first_q;

	logic                             out_valid_q;
	logic                             reply_q;
	logic [pbb_pkg::MASK_BANDS-1:0]   dmask_q;
	logic [pbb_pkg::KIND_W-1:0]       dkind_q;
	logic [pbb_pkg::SEL_W-1:0]        dfirst_q;
	logic [pbb_pkg::CNT_W-1:0]        count_q;

	logic                             accept;
	logic                             slot_free;
	logic                             is_vertex;
	logic                             is_read;
	logic                             is_clear;
	logic signed [pbb_pkg::Y_W-1:0]   new_min;
	logic signed [pbb_pkg::Y_W-1:0]   new_max;
	logic [N_W-1:0]                   n_eff;
	logic                             div_start;
	logic                             div_done;
	logic [pbb_pkg::H_W-1:0]          div_quo;
	logic [N_W-1:0]                   div_rem;
	logic [N_W:0]                     rsum;
	logic                             carry;
	logic [pbb_pkg::H_W-1:0]          hi_bnd;
	logic [N_W-1:0]                   rem_next;
	logic signed [CMP_W-1:0]          lo_c;
	logic signed [CMP_W-1:0]          hi_c;
	logic signed [CMP_W-1:0]          min_c;
	logic signed [CMP_W-1:0]          max_c;
	logic                             hit;
	logic                             walk_last;
	pbb_pkg::cnt_req_t                cnt_req;
	logic [pbb_pkg::CNT_W-1:0]        cnt_rd;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign is_vertex = accept && (command == pbb_pkg::CMD_VERTEX);
	assign is_read   = accept && (command == pbb_pkg::CMD_READ);
	assign is_clear  = accept && (command == pbb_pkg::CMD_CLEAR);

	// Fold the incoming vertex into the running extent.
	always_comb begin
		if (!inside_q) begin
			new_min = vertex_y;
			new_max = vertex_y;
		end else begin
			new_min = (vertex_y < min_q) ? vertex_y : min_q;
			new_max = (vertex_y > max_q) ? vertex_y : max_q;
		end
	end

	// Clamp the band count to the range the mask and counters support.
	always_comb begin
		priority if (bands_q == '0)
			n_eff = N_W'(1);
		else if (bands_q > N_W'(MAXB))
			n_eff = N_W'(MAXB);
		else
			n_eff = bands_q;
	end

	assign div_start = is_vertex && last_vertex;

	pbb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (height_q),
		.divisor  (n_eff),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Next boundary: floor(h*(i+1)/n) from floor(h*i/n) and its remainder.
	always_comb begin
		rsum     = {1'b0, rem_q} + {1'b0, hr_q};
		carry    = rsum >= {1'b0, n_q};
		rem_next = carry ? N_W'(rsum - {1'b0, n_q}) : N_W'(rsum);
		hi_bnd   = lo_q + hq_q + pbb_pkg::H_W'(carry);
		lo_c     = $signed(CMP_W'(lo_q) << COORD_FRAC_BITS);
		hi_c     = $signed(CMP_W'(hi_bnd) << COORD_FRAC_BITS);
		min_c    = CMP_W'(min_q);
		max_c    = CMP_W'(max_q);
		hit      = (min_c <= hi_c) && (max_c >= lo_c);
		walk_last = ({1'b0, idx_q} == N_W'(n_q - N_W'(1)));
	end

	always_comb begin
		cnt_req.inc = (state_q == ST_WALK) && hit;
		cnt_req.clr = is_clear;
		cnt_req.idx = idx_q;
	end

	pbb_counters #(
		.DEPTH (MAXB)
	) u_cnt (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (cnt_req),
		.rd_sel  (sel_q),
		.rd_data (cnt_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= pbb_pkg::HEIGHT_RST;
			bands_q  <= pbb_pkg::BANDS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pbb_pkg::REG_HEIGHT: height_q <= cfg_data;
				pbb_pkg::REG_BANDS:  bands_q  <= cfg_data[N_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			min_q    <= '0;
			max_q    <= '0;
			inside_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (is_vertex) begin
						min_q    <= new_min;
						max_q    <= new_max;
						inside_q <= !last_vertex;
						if (last_vertex)
							state_q <= ST_DIV;
					end else if (is_read) begin
						state_q <= ST_RD;
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (walk_last)
						state_q <= ST_DONE;
				end
				ST_DONE, ST_RD: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Walk datapath: boundary, remainder and hit summary per band.
	always_ff @(posedge clk) begin
		if (div_start) begin
			n_q <= n_eff;
		end
		if (is_read) begin
			sel_q <= band_select;
		end
		if (state_q == ST_DIV) begin
			hq_q    <= div_quo;
			hr_q    <= div_rem;
			lo_q    <= '0;
			rem_q   <= '0;
			idx_q   <= '0;
			mask_q  <= '0;
			kind_q  <= pbb_pkg::DEST_NONE;
			first_q <= '0;
		end else if (state_q == ST_WALK) begin
			lo_q  <= hi_bnd;
			rem_q <= rem_next;
			idx_q <= idx_q + pbb_pkg::SEL_W'(1);
			if (hit) begin
				mask_q[idx_q] <= 1'b1;
				unique case (kind_q)
					pbb_pkg::DEST_NONE: begin
						kind_q  <= pbb_pkg::DEST_ONE;
						first_q <= idx_q;
					end
					pbb_pkg::DEST_ONE:  kind_q <= pbb_pkg::DEST_MANY;
					default:            kind_q <= pbb_pkg::DEST_MANY;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE || state_q == ST_RD) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && slot_free) begin
			reply_q  <= pbb_pkg::REPLY_ROUTE;
			dmask_q  <= mask_q;
			dkind_q  <= kind_q;
			dfirst_q <= first_q;
			count_q  <= '0;
		end else if (state_q == ST_RD && slot_free) begin
			reply_q  <= pbb_pkg::REPLY_COUNT;
			dmask_q  <= '0;
			dkind_q  <= pbb_pkg::DEST_NONE;
			dfirst_q <= '0;
			count_q  <= cnt_rd;
		end
	end

	assign out_valid   = out_valid_q;
	assign reply_kind  = reply_q;
	assign dest_mask   = dmask_q;
	assign dest_kind   = dkind_q;
	assign first_dest  = dfirst_q;
	assign count_value = count_q;

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> {1'b0, idx_q} < n_q)
		else $error("band walk index past band count");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && div_done |-> div_rem < n_eff)
		else $error("divider remainder not below band count");

	a_kind_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_kind == pbb_pkg::REPLY_ROUTE |->
		(dest_kind == pbb_pkg::DEST_NONE && dest_mask == '0) ||
		(dest_kind == pbb_pkg::DEST_ONE && $onehot(dest_mask)) ||
		(dest_kind == pbb_pkg::DEST_MANY && $countones(dest_mask) > 1))
		else $error("destination kind disagrees with mask");

	a_first_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_kind == pbb_pkg::REPLY_ROUTE &&
		dest_kind != pbb_pkg::DEST_NONE |-> dest_mask[first_dest])
		else $error("first destination not in mask");

	a_count_reply_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_kind == pbb_pkg::REPLY_COUNT |->
		dest_mask == '0 && first_dest == '0)
		else $error("count reply carries routing fields");

endmodule
